[rtl/core/pbts_pkg.sv]
package pbts_pkg;

  // Action codes carried in the low bits of an input word.
  typedef enum logic [2:0] {
    ActAdd    = 3'd0,
    ActDelay  = 3'd1,
    ActTick   = 3'd2,
    ActLock   = 3'd3,
    ActUnlock = 3'd4,
    ActStart  = 3'd5
  } action_e;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned PrioW    = 5;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned LockW    = 8;
  localparam int unsigned ReadyW   = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Slot indexes between units are carried at the width of the largest
  // supported slot count.
  localparam int unsigned IdxW = 6;

  localparam logic [LockW-1:0] LockMax = 8'd255;

  typedef struct packed {
    logic            done;
    logic            expire;
    logic [IdxW-1:0] idx;
  } tick_stat_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [IdxW-1:0] idx;
  } scan_res_t;

endpackage

[rtl/core/pbts_cdmem.sv]
module pbts_cdmem #(
  parameter int PRIO_LEVELS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [PRIO_LEVELS-1:0]         delayed_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(PRIO_LEVELS)-1:0] wr_addr_i,
  input  logic [pbts_pkg::CountW-1:0]    wr_data_i,
  output pbts_pkg::tick_stat_t           stat_o
);

  localparam int PW = $clog2(PRIO_LEVELS);
  localparam logic [PW-1:0] LastIdx = PW'(PRIO_LEVELS - 1);

  logic [pbts_pkg::CountW-1:0] mem [PRIO_LEVELS];

  logic                        sweep_q;
  logic [PW-1:0]               cnt_q;
  logic                        st1_go_q;
  logic                        st1_act_q;
  logic                        st1_last_q;
  logic [PW-1:0]               st1_idx_q;
  logic [pbts_pkg::CountW-1:0] rd_data_q;
  logic [pbts_pkg::CountW-1:0] dec;
  logic                        rd_en;
  logic                        we;
  logic [PW-1:0]               waddr;
  logic [pbts_pkg::CountW-1:0] wdata;

  assign rd_en = sweep_q & delayed_i[cnt_q];
  // The single decrementer is shared by every slot in turn.
  assign dec   = rd_data_q - 32'd1;
  assign we    = st1_act_q | wr_en_i;
  assign waddr = st1_act_q ? st1_idx_q : wr_addr_i;
  assign wdata = st1_act_q ? dec : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= 1'b0;
      cnt_q      <= '0;
      st1_go_q   <= 1'b0;
      st1_act_q  <= 1'b0;
      st1_last_q <= 1'b0;
    end else begin
      st1_go_q   <= sweep_q;
      st1_act_q  <= rd_en;
      st1_last_q <= sweep_q && (cnt_q == LastIdx);
      if (start_i) begin
        sweep_q <= 1'b1;
        cnt_q   <= '0;
      end else if (sweep_q) begin
        if (cnt_q == LastIdx) begin
          sweep_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st1_idx_q <= cnt_q;
    if (rd_en) begin
      rd_data_q <= mem[cnt_q];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign stat_o.done   = st1_go_q & st1_last_q;
  assign stat_o.expire = st1_act_q & (dec == '0);
  assign stat_o.idx    = pbts_pkg::IdxW'(st1_idx_q);

endmodule

[rtl/core/pbts_scan.sv]
module pbts_scan #(
  parameter int PRIO_LEVELS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [PRIO_LEVELS-1:0] mask_i,
  output pbts_pkg::scan_res_t    res_o
);

  localparam int NGrp = (PRIO_LEVELS + 7) / 8;
  localparam int MW   = NGrp * 8;
  localparam int GW   = (NGrp > 1) ? $clog2(NGrp) : 1;
  localparam logic [GW-1:0] LastGrp = GW'(NGrp - 1);

  logic          busy_q;
  logic [GW-1:0] grp_q;
  logic [MW-1:0] mask_q;
  logic          hit;
  logic [2:0]    pos;
  logic          last;

  // Lowest set bit of the byte now under test.
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int b = 7; b >= 0; b--) begin
      if (mask_q[b]) begin
        hit = 1'b1;
        pos = 3'(b);
      end
    end
  end

  assign last = (grp_q == LastGrp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      grp_q  <= '0;
    end else if (busy_q) begin
      if (hit || last) begin
        busy_q <= 1'b0;
      end
      grp_q <= grp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mask_q <= MW'(mask_i);
    end else if (busy_q) begin
      mask_q <= mask_q >> 8;
    end
  end

  assign res_o.done  = busy_q & (hit | last);
  assign res_o.found = hit;
  assign res_o.idx   = (pbts_pkg::IdxW'(grp_q) << 3) | pbts_pkg::IdxW'(pos);

endmodule

[rtl/core/priority_bitmap_task_scheduler_top.sv]
// One result word per input word; the next word is taken once the result has moved to the
// output register. Add, lock, unused codes, an unlock that leaves the lock held and a delay
// with no running slot or with the lock held go straight to the result. A delay of the running
// slot with the lock free, an unlock to zero and start add a ready scan of one bitmap byte per
// cycle; a tick adds a countdown sweep of the delayed slots first, then a scan if unlocked.
// Asynchronous active-low reset clears the bitmaps, running slot and lock depth; countdowns are kept.
module priority_bitmap_task_scheduler_top #(
  parameter int PRIO_LEVELS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] action, [7:3] task_prio, [39:8] sleep length in ticks
  input  logic [pbts_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] switch_request, [5:1] running_prio, [6] running_valid,
  // [38:7] ready_bits, [46:39] lock_level, [47] zero
  output logic [pbts_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int PW  = $clog2(PRIO_LEVELS);
  localparam int PWX = (PW > pbts_pkg::PrioW) ? PW : pbts_pkg::PrioW;
  localparam int RWX = (PRIO_LEVELS > pbts_pkg::ReadyW) ? PRIO_LEVELS : pbts_pkg::ReadyW;
  localparam logic [PW-1:0] IdleSlot = PW'(PRIO_LEVELS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StTick,
    StScan,
    StFinish
  } state_e;

  state_e                          state_q, state_d;
  logic [PRIO_LEVELS-1:0]          ready_q, ready_d;
  logic [PRIO_LEVELS-1:0]          delayed_q, delayed_d;
  logic [PW-1:0]                   cur_q, cur_d;
  logic                            valid_q, valid_d;
  logic [pbts_pkg::LockW-1:0]      lock_q, lock_d;
  logic                            sw_q, sw_d;
  logic                            tick_start_q, tick_start_d;
  logic                            scan_start_q, scan_start_d;
  logic                            out_valid_q, out_valid_d;
  logic [pbts_pkg::OutDataW-1:0]   out_data_q, out_data_d;

  pbts_pkg::action_e               action;
  logic [pbts_pkg::PrioW-1:0]      task_prio;
  logic [pbts_pkg::TicksW-1:0]     sleep_ticks;
  logic [PWX-1:0]                  prio_x;
  logic [PWX-1:0]                  cur_x;
  logic [RWX-1:0]                  ready_x;
  logic                            in_acc;
  logic                            mem_we;
  pbts_pkg::tick_stat_t            tick_stat;
  pbts_pkg::scan_res_t             scan_res;

  assign action      = pbts_pkg::action_e'(s_axis_tdata[2:0]);
  assign task_prio   = s_axis_tdata[7:3];
  assign sleep_ticks = s_axis_tdata[39:8];
  assign prio_x      = PWX'(task_prio);
  assign cur_x       = PWX'(cur_q);
  assign ready_x     = RWX'(ready_q);

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign mem_we        = in_acc && (action == pbts_pkg::ActDelay) && valid_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pbts_cdmem #(
    .PRIO_LEVELS(PRIO_LEVELS)
  ) u_cdmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (tick_start_q),
    .delayed_i(delayed_q),
    .wr_en_i  (mem_we),
    .wr_addr_i(cur_q),
    .wr_data_i(sleep_ticks),
    .stat_o   (tick_stat)
  );

  pbts_scan #(
    .PRIO_LEVELS(PRIO_LEVELS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(scan_start_q),
    .mask_i (ready_q),
    .res_o  (scan_res)
  );

  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    delayed_d    = delayed_q;
    cur_d        = cur_q;
    valid_d      = valid_q;
    lock_d       = lock_q;
    sw_d         = sw_q;
    tick_start_d = 1'b0;
    scan_start_d = 1'b0;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_data_d   = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          sw_d    = 1'b0;
          state_d = StFinish;
          case (action)
            pbts_pkg::ActAdd: begin
              if (32'(task_prio) < PRIO_LEVELS) begin
                ready_d[prio_x[PW-1:0]]   = 1'b1;
                delayed_d[prio_x[PW-1:0]] = 1'b0;
              end
            end
            pbts_pkg::ActDelay: begin
              if (valid_q) begin
                delayed_d[cur_q] = 1'b1;
                ready_d[cur_q]   = 1'b0;
                if (lock_q == '0) begin
                  scan_start_d = 1'b1;
                  state_d      = StScan;
                end
              end
            end
            pbts_pkg::ActTick: begin
              tick_start_d = 1'b1;
              state_d      = StTick;
            end
            pbts_pkg::ActLock: begin
              if (lock_q != pbts_pkg::LockMax) begin
                lock_d = lock_q + 1'b1;
              end
            end
            pbts_pkg::ActUnlock: begin
              if (lock_q != '0) begin
                lock_d = lock_q - 1'b1;
                if (lock_q == 8'd1) begin
                  scan_start_d = 1'b1;
                  state_d      = StScan;
                end
              end
            end
            pbts_pkg::ActStart: begin
              lock_d            = '0;
              delayed_d         = '0;
              ready_d[IdleSlot] = 1'b1;
              scan_start_d      = 1'b1;
              state_d           = StScan;
            end
            default: begin
            end
          endcase
        end
      end
      StTick: begin
        if (tick_stat.expire) begin
          ready_d[tick_stat.idx[PW-1:0]]   = 1'b1;
          delayed_d[tick_stat.idx[PW-1:0]] = 1'b0;
        end
        if (tick_stat.done) begin
          if (lock_q == '0) begin
            scan_start_d = 1'b1;
            state_d      = StScan;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StScan: begin
        if (scan_res.done) begin
          if (scan_res.found && !(valid_q && (scan_res.idx[PW-1:0] == cur_q))) begin
            sw_d    = 1'b1;
            cur_d   = scan_res.idx[PW-1:0];
            valid_d = 1'b1;
          end
          state_d = StFinish;
        end
      end
      StFinish: begin
        // The result waits here only while the previous word is still unread.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, lock_q, ready_x[pbts_pkg::ReadyW-1:0], valid_q,
                         cur_x[pbts_pkg::PrioW-1:0], sw_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ready_q      <= '0;
      delayed_q    <= '0;
      cur_q        <= '0;
      valid_q      <= 1'b0;
      lock_q       <= '0;
      sw_q         <= 1'b0;
      tick_start_q <= 1'b0;
      scan_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ready_q      <= ready_d;
      delayed_q    <= delayed_d;
      cur_q        <= cur_d;
      valid_q      <= valid_d;
      lock_q       <= lock_d;
      sw_q         <= sw_d;
      tick_start_q <= tick_start_d;
      scan_start_q <= scan_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

[rtl/core/pbts_checker.sv]
module pbts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [pbts_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pbts_pkg::OutDataW-1:0] m_axis_tdata
);

  // One word is worked on at a time, so acceptance is never back to back.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in two consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // A switch always leaves a valid running slot behind.
  a_switch_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[6])
    else $error("switch reported without a running slot");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[47])
    else $error("result padding bit set");

  // An offered result word carries no unknown bits.
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown(m_axis_tdata))
    else $error("result word has unknown bits");

endmodule

bind priority_bitmap_task_scheduler_top pbts_checker u_pbts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
